>>> sv/prc_pkg.sv
package prc_pkg;

   // Default CORDIC depth and the size of the table that bounds it.
   localparam int CORDIC_ITERATIONS = 16;
   localparam int TABLE_LEN         = 24;
   localparam int QUEUE_DEPTH_DEF   = 4;

   // Field widths.
   localparam int VALUE_W  = 16;
   localparam int RESULT_W = 17;

   // Internal datapath: coordinates are Q8.16, angles are radians times 2^24.
   localparam int XY_W           = 28;
   localparam int Z_W            = 28;
   localparam int COORD_SHIFT    = 8;
   localparam int ANGLE_IN_SHIFT = 11;

   // Gain correction, Q0.24.
   localparam int GAIN_W = 24;
   localparam int PROD_W = XY_W + GAIN_W + 1;
   localparam logic [GAIN_W-1:0] GAIN_K = 24'd10188014;

   // Angle constants, radians times 2^24.
   localparam logic signed [Z_W-1:0] PI_24      = 28'sd52707179;
   localparam logic signed [Z_W-1:0] HALF_PI_24 = 28'sd26353589;
   localparam logic signed [Z_W-1:0] TWO_PI_24  = 28'sd105414358;

   // Result limits.
   localparam logic signed [RESULT_W-1:0] PI_Q13     = 17'sd25736;
   localparam logic signed [RESULT_W-1:0] RESULT_MAX = 17'sd65535;
   localparam logic signed [RESULT_W-1:0] RESULT_MIN = -17'sd65536;

   typedef enum logic {
      CONV_POLAR_TO_RECT = 1'b0,
      CONV_RECT_TO_POLAR = 1'b1
   } conv_mode_type;

   // One transaction as it travels from the front end to the CORDIC pipeline.
   typedef struct packed {
      conv_mode_type           mode;
      logic                    origin;
      logic signed [XY_W-1:0]  x;
      logic signed [XY_W-1:0]  y;
      logic signed [Z_W-1:0]   z;
   } cordic_type;

   // atan(2^-idx) in radians times 2^24, rounded to nearest.
   function automatic logic signed [Z_W-1:0] atan_entry(input int unsigned idx);
      logic signed [Z_W-1:0] res;
      case (idx)
         0:       res = 28'sd13176795;
         1:       res = 28'sd7778716;
         2:       res = 28'sd4110060;
         3:       res = 28'sd2086331;
         4:       res = 28'sd1047214;
         5:       res = 28'sd524117;
         6:       res = 28'sd262123;
         7:       res = 28'sd131069;
         8:       res = 28'sd65536;
         9:       res = 28'sd32768;
         10:      res = 28'sd16384;
         11:      res = 28'sd8192;
         12:      res = 28'sd4096;
         13:      res = 28'sd2048;
         14:      res = 28'sd1024;
         15:      res = 28'sd512;
         16:      res = 28'sd256;
         17:      res = 28'sd128;
         18:      res = 28'sd64;
         19:      res = 28'sd32;
         20:      res = 28'sd16;
         21:      res = 28'sd8;
         22:      res = 28'sd4;
         23:      res = 28'sd2;
         default: res = '0;
      endcase
      return res;
   endfunction

endpackage

>>> sv/polar_rectangular_converter.sv
// Channel    | Direction | Handshake             | Payload
// request    | in        | req_valid / req_stall | req_type, req_first_value, req_second_value
// response   | out       | rsp_valid / rsp_stall | rsp_first_result, rsp_second_result
//
// A transaction is taken every cycle while the four-entry front queue has room.
// Without stalls a transaction passes through its queue entry, one register per
// CORDIC micro-rotation, the gain multiplier register and the rounding register.
// Reset is synchronous and clears only the queue pointers, the queue count and the valid bits.
// A stalled response freezes the pipeline; the queue keeps taking transactions
// until it is full, and only then is req_stall raised.
//
// The front end converts each request to the internal fixed-point formats and
// applies the quarter-turn pre-rotation, so that every transaction enters the
// queue ready for the iterations. The back end is a fully pipelined CORDIC in
// which each stage performs one micro-rotation in rotation or vectoring mode,
// chosen per transaction, followed by a registered gain multiplier and a
// rounding and clamping stage that feeds the response register.
module polar_rectangular_converter #(
   parameter int ITERATIONS  = prc_pkg::CORDIC_ITERATIONS,
   parameter int QUEUE_DEPTH = prc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic signed [prc_pkg::VALUE_W-1:0]   req_first_value,
   input  logic signed [prc_pkg::VALUE_W-1:0]   req_second_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [prc_pkg::RESULT_W-1:0]  rsp_first_result,
   output logic signed [prc_pkg::RESULT_W-1:0]  rsp_second_result
);
   import prc_pkg::*;

   // Transactions leaving the front end and those waiting at the queue head.
   cordic_type push_item;
   cordic_type head_item;
   logic       push;
   logic       queue_full;
   logic       head_valid;
   logic       pop;

   prc_front u_front (
      .req_valid    (req_valid),
      .req_type     (req_type),
      .first_value  (req_first_value),
      .second_value (req_second_value),
      .queue_full   (queue_full),
      .req_stall    (req_stall),
      .push         (push),
      .item         (push_item)
   );

   // The queue decouples the request side from stalls on the response side.
   prc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (head_valid),
      .head_item (head_item)
   );

   prc_back #(
      .ITERATIONS (ITERATIONS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_item     (head_item),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .first_result  (rsp_first_result),
      .second_result (rsp_second_result)
   );

endmodule

>>> sv/prc_front.sv
module prc_front (
   input  logic                                req_valid,
   input  logic                                req_type,
   input  logic signed [prc_pkg::VALUE_W-1:0]  first_value,
   input  logic signed [prc_pkg::VALUE_W-1:0]  second_value,
   input  logic                                queue_full,
   output logic                                req_stall,
   output logic                                push,
   output prc_pkg::cordic_type                 item
);
   import prc_pkg::*;

   logic signed [XY_W-1:0] a_q;
   logic signed [XY_W-1:0] b_q;
   logic signed [Z_W-1:0]  z_raw;
   logic signed [Z_W-1:0]  z_wrap;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Scale the inputs to the internal formats.
   assign a_q   = {{(XY_W-VALUE_W-COORD_SHIFT){first_value[VALUE_W-1]}},
                   first_value, {COORD_SHIFT{1'b0}}};
   assign b_q   = {{(XY_W-VALUE_W-COORD_SHIFT){second_value[VALUE_W-1]}},
                   second_value, {COORD_SHIFT{1'b0}}};
   assign z_raw = {{(Z_W-VALUE_W-ANGLE_IN_SHIFT){second_value[VALUE_W-1]}},
                   second_value, {ANGLE_IN_SHIFT{1'b0}}};

   // The input range needs at most one wrap into -pi to pi.
   always_comb begin
      if (z_raw > PI_24) begin
         z_wrap = z_raw - TWO_PI_24;
      end else if (z_raw < -PI_24) begin
         z_wrap = z_raw + TWO_PI_24;
      end else begin
         z_wrap = z_raw;
      end
   end

   // Pre-rotate by a quarter turn so that the iterations stay within half pi.
   always_comb begin
      item.mode   = conv_mode_type'(req_type);
      item.origin = 1'b0;
      item.x      = a_q;
      item.y      = '0;
      item.z      = '0;
      if (item.mode == CONV_POLAR_TO_RECT) begin
         if (z_wrap > HALF_PI_24) begin
            item.x = '0;
            item.y = a_q;
            item.z = z_wrap - HALF_PI_24;
         end else if (z_wrap < -HALF_PI_24) begin
            item.x = '0;
            item.y = -a_q;
            item.z = z_wrap + HALF_PI_24;
         end else begin
            item.x = a_q;
            item.y = '0;
            item.z = z_wrap;
         end
      end else begin
         item.origin = (first_value == '0) && (second_value == '0);
         if (a_q < 0) begin
            if (b_q >= 0) begin
               item.x = b_q;
               item.y = -a_q;
               item.z = HALF_PI_24;
            end else begin
               item.x = -b_q;
               item.y = a_q;
               item.z = -HALF_PI_24;
            end
         end else begin
            item.x = a_q;
            item.y = b_q;
            item.z = '0;
         end
      end
   end

endmodule

>>> sv/prc_queue.sv
module prc_queue #(
   parameter int DEPTH = prc_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  prc_pkg::cordic_type  push_item,
   output logic                 full,
   input  logic                 pop,
   output logic                 not_empty,
   output prc_pkg::cordic_type  head_item
);
   import prc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cordic_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_item = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> sv/prc_back.sv
module prc_back #(
   parameter int ITERATIONS = prc_pkg::CORDIC_ITERATIONS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 head_valid,
   input  prc_pkg::cordic_type                  head_item,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [prc_pkg::RESULT_W-1:0]  first_result,
   output logic signed [prc_pkg::RESULT_W-1:0]  second_result
);
   import prc_pkg::*;

   localparam int GAIN_SHIFT  = 32;
   localparam int ANGLE_SHIFT = 11;
   localparam logic signed [PROD_W-1:0] GAIN_ROUND  = PROD_W'(64'sd2147483648);
   localparam logic signed [Z_W-1:0]    ANGLE_ROUND = Z_W'(1024);

   cordic_type               stage_in [ITERATIONS];
   cordic_type               stage_ff [ITERATIONS];
   logic [ITERATIONS-1:0]    stage_vld_ff;

   logic signed [PROD_W-1:0] prod_x_in, prod_y_in;
   logic signed [PROD_W-1:0] prod_x_ff, prod_y_ff;
   logic signed [Z_W-1:0]    angle_ff;
   conv_mode_type            mode_ff;
   logic                     origin_ff;
   logic                     prod_vld_ff;

   logic signed [PROD_W-1:0] scaled_x, scaled_y;
   logic signed [Z_W-1:0]    angle_sh;
   logic signed [RESULT_W-1:0] first_in, second_in;
   logic signed [RESULT_W-1:0] first_ff, second_ff;
   logic                     rsp_valid_ff;
   logic                     advance;

   function automatic logic signed [RESULT_W-1:0] clamp_result(
      input logic signed [PROD_W-1:0] v);
      logic signed [RESULT_W-1:0] res;
      if (v > PROD_W'(RESULT_MAX)) begin
         res = RESULT_MAX;
      end else if (v < PROD_W'(RESULT_MIN)) begin
         res = RESULT_MIN;
      end else begin
         res = v[RESULT_W-1:0];
      end
      return res;
   endfunction

   // The whole pipeline moves together; it holds only when a finished result waits.
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign pop     = advance && head_valid;

   for (genvar i = 0; i < ITERATIONS; i++) begin : g_iter
      cordic_type             src;
      logic signed [XY_W-1:0] dx, dy;
      logic                   turn_pos;

      if (i == 0) begin : g_first
         assign src = head_item;
      end else begin : g_next
         assign src = stage_ff[i-1];
      end

      always_comb begin
         dx = src.y >>> i;
         dy = src.x >>> i;
         if (src.mode == CONV_POLAR_TO_RECT) begin
            turn_pos = !src.z[Z_W-1];
         end else begin
            turn_pos = src.y[XY_W-1];
         end
         stage_in[i] = src;
         if (turn_pos) begin
            stage_in[i].x = src.x - dx;
            stage_in[i].y = src.y + dy;
            stage_in[i].z = src.z - atan_entry(i);
         end else begin
            stage_in[i].x = src.x + dx;
            stage_in[i].y = src.y - dy;
            stage_in[i].z = src.z + atan_entry(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < ITERATIONS; k++) begin
            stage_ff[k] <= stage_in[k];
         end
      end
   end

   // Gain correction product.
   assign prod_x_in = PROD_W'(stage_ff[ITERATIONS-1].x) * PROD_W'($signed({1'b0, GAIN_K}));
   assign prod_y_in = PROD_W'(stage_ff[ITERATIONS-1].y) * PROD_W'($signed({1'b0, GAIN_K}));

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
         angle_ff  <= stage_ff[ITERATIONS-1].z;
         mode_ff   <= stage_ff[ITERATIONS-1].mode;
         origin_ff <= stage_ff[ITERATIONS-1].origin;
      end
   end

   // Round half up to Q8.8 and Q3.13, then clamp.
   assign scaled_x = (prod_x_ff + GAIN_ROUND) >>> GAIN_SHIFT;
   assign scaled_y = (prod_y_ff + GAIN_ROUND) >>> GAIN_SHIFT;
   assign angle_sh = (angle_ff + ANGLE_ROUND) >>> ANGLE_SHIFT;

   always_comb begin
      first_in = clamp_result(scaled_x);
      if (mode_ff == CONV_POLAR_TO_RECT) begin
         second_in = clamp_result(scaled_y);
      end else if (origin_ff) begin
         first_in  = '0;
         second_in = '0;
      end else if (angle_sh > Z_W'(PI_Q13)) begin
         second_in = PI_Q13;
      end else if (angle_sh < -Z_W'(PI_Q13)) begin
         second_in = -PI_Q13;
      end else begin
         second_in = angle_sh[RESULT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_vld_ff <= '0;
         prod_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         stage_vld_ff <= {stage_vld_ff[ITERATIONS-2:0], head_valid};
         prod_vld_ff  <= stage_vld_ff[ITERATIONS-1];
         rsp_valid_ff <= prod_vld_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign first_result  = first_ff;
   assign second_result = second_ff;

endmodule

>>> sv/prc_checker.sv
module prc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [prc_pkg::RESULT_W-1:0]  rsp_first_result,
   input logic signed [prc_pkg::RESULT_W-1:0]  rsp_second_result
);
   import prc_pkg::*;

   // Neither a coordinate, a radius nor an angle can reach beyond this.
   localparam logic signed [RESULT_W-1:0] RESULT_BOUND = 17'sd47000;

   a_rsp_held : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_first_result) && $stable(rsp_second_result))
      else $error("response payload changed while stalled");

   a_reset_clears : assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   a_result_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_first_result <= RESULT_BOUND && rsp_first_result >= -RESULT_BOUND
                 && rsp_second_result <= RESULT_BOUND && rsp_second_result >= -RESULT_BOUND)
      else $error("result outside the reachable range");

endmodule

bind polar_rectangular_converter prc_checker u_prc_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_first_result  (rsp_first_result),
   .rsp_second_result (rsp_second_result)
);

>>> tb/tb_polar_rectangular_converter.sv
module tb_polar_rectangular_converter;

   timeunit 1ns;
   timeprecision 1ps;

   import prc_pkg::conv_mode_type;
   import prc_pkg::CONV_POLAR_TO_RECT;
   import prc_pkg::CONV_RECT_TO_POLAR;

   // The converter is built with its default depth, and the predictor below runs
   // the same number of micro-rotations.
   localparam int CORDIC_STEPS = prc_pkg::CORDIC_ITERATIONS;

   // Angles inside the predictor are radians scaled by 2^24, as in the datapath.
   localparam longint ANG_PI       = 52707179;
   localparam longint ANG_HALF_PI  = 26353589;
   localparam longint ANG_TWO_PI   = 105414358;
   localparam longint ANG_PI_Q13   = 25736;
   localparam longint GAIN_Q24     = 10188014;
   localparam int     ARCTAN_LEN   = 24;

   // The pipeline is ITERATIONS + 3 deep; the tail wait leaves ample margin.
   localparam int     TAIL_CYCLES  = 64;
   localparam int     RANDOM_ITEMS = 1750;

   // One request transaction waiting to be offered, with the idle cycles that
   // precede it and a flag that makes the sender wait for the pipeline to drain.
   typedef struct packed {
      conv_mode_type       mode;
      logic signed [15:0]  first_value;
      logic signed [15:0]  second_value;
      logic [4:0]          gap;
      logic                drain;
   } coord_request_type;

   // The two result fields that a conversion produces.
   typedef struct packed {
      logic signed [16:0]  first;
      logic signed [16:0]  second;
   } coord_result_type;

   // A predicted result, kept with the request that caused it for diagnostics.
   typedef struct packed {
      conv_mode_type       mode;
      logic signed [15:0]  first_value;
      logic signed [15:0]  second_value;
      coord_result_type    result;
   } awaited_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                req_valid        = 1'b0;
   logic                req_stall;
   logic                req_type         = 1'b0;
   logic signed [15:0]  req_first_value  = '0;
   logic signed [15:0]  req_second_value = '0;
   logic                rsp_valid;
   logic                rsp_stall        = 1'b0;
   logic signed [16:0]  rsp_first_result;
   logic signed [16:0]  rsp_second_result;

   // atan(2^-i) in radians times 2^24, rounded to nearest.
   longint arctan_step [ARCTAN_LEN] = '{
      13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
      65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128, 64, 32, 16, 8, 4, 2
   };

   coord_request_type   pending_requests [$];
   awaited_result_type  awaited_results [$];

   // Written by the scoreboard with a nonblocking assignment, so that the sender
   // and the end-of-run logic always see a settled value.
   int   results_owed   = 0;

   int   mismatch_count = 0;
   logic sender_calm    = 1'b0;

   polar_rectangular_converter #(
      .ITERATIONS (CORDIC_STEPS)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_first_value   (req_first_value),
      .req_second_value  (req_second_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_first_result  (rsp_first_result),
      .rsp_second_result (rsp_second_result)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Applies the CORDIC gain to a Q8.16 magnitude, rounding half up to Q8.8.
   function automatic longint apply_gain(longint value);
      return (value * GAIN_Q24 + (64'sd1 <<< 31)) >>> 32;
   endfunction

   // Saturates to the 17 bit signed range of the result ports.
   function automatic logic signed [16:0] saturate17(longint value);
      if (value > 65535) begin
         return 17'sd65535;
      end
      if (value < -65536) begin
         return -17'sd65536;
      end
      return 17'(value);
   endfunction

   // Works out what the converter should return for one request. Polar input
   // runs the CORDIC in rotation mode, rectangular input in vectoring mode.
   function automatic coord_result_type predict_conversion(conv_mode_type mode,
         logic signed [15:0] first_in, logic signed [15:0] second_in);
      coord_result_type res;
      longint x;
      longint y;
      longint z;
      longint dx;
      longint dy;
      longint held;
      longint angle;
      int     step;
      res = '0;
      x = longint'(first_in) * 256;
      y = longint'(second_in) * 256;
      z = 0;
      if (mode == CONV_POLAR_TO_RECT) begin
         // The radius starts on the x axis; the angle is wrapped into -pi to pi
         // and a quarter turn is taken up front where its magnitude exceeds half pi.
         z = longint'(second_in) * 2048;
         y = 0;
         if (z > ANG_PI) begin
            z -= ANG_TWO_PI;
         end else if (z < -ANG_PI) begin
            z += ANG_TWO_PI;
         end
         if (z > ANG_HALF_PI) begin
            y = x;
            x = 0;
            z -= ANG_HALF_PI;
         end else if (z < -ANG_HALF_PI) begin
            y = -x;
            x = 0;
            z += ANG_HALF_PI;
         end
         for (step = 0; step < CORDIC_STEPS && step < ARCTAN_LEN; step++) begin
            dx = y >>> step;
            dy = x >>> step;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= arctan_step[step];
            end else begin
               x += dx;
               y -= dy;
               z += arctan_step[step];
            end
         end
         res.first  = saturate17(apply_gain(x));
         res.second = saturate17(apply_gain(y));
      end else if (first_in != 0 || second_in != 0) begin
         // A vector in the left half plane is turned by a quarter turn first,
         // which lets the angle cover all four quadrants.
         if (x < 0) begin
            held = x;
            if (y >= 0) begin
               x = y;
               y = -held;
               z = ANG_HALF_PI;
            end else begin
               x = -y;
               y = held;
               z = -ANG_HALF_PI;
            end
         end
         for (step = 0; step < CORDIC_STEPS && step < ARCTAN_LEN; step++) begin
            dx = y >>> step;
            dy = x >>> step;
            if (y < 0) begin
               x -= dx;
               y += dy;
               z -= arctan_step[step];
            end else begin
               x += dx;
               y -= dy;
               z += arctan_step[step];
            end
         end
         angle = (z + 1024) >>> 11;
         if (angle > ANG_PI_Q13) begin
            angle = ANG_PI_Q13;
         end else if (angle < -ANG_PI_Q13) begin
            angle = -ANG_PI_Q13;
         end
         res.first  = saturate17(apply_gain(x));
         res.second = saturate17(angle);
      end
      return res;
   endfunction

   // Idle or stall length for one transaction: mostly none, sometimes short,
   // now and then long.
   function automatic int unsigned draw_wait();
      int unsigned roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
         return 0;
      end
      if (roll < 8) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(4, 18);
   endfunction

   // A coordinate value: full range, near zero, an edge value or a power of two.
   function automatic logic signed [15:0] pick_value();
      int unsigned roll;
      logic signed [15:0] value;
      roll = $urandom_range(0, 9);
      if (roll < 5) begin
         value = 16'($urandom_range(0, 65535));
      end else if (roll < 8) begin
         value = 16'(int'($urandom_range(0, 1024)) - 512);
      end else if (roll == 8) begin
         case ($urandom_range(0, 4))
            0:       value = 16'sd0;
            1:       value = 16'sd1;
            2:       value = -16'sd1;
            3:       value = 16'sd32767;
            default: value = -16'sd32768;
         endcase
      end else begin
         value = 16'sd1 <<< $urandom_range(0, 14);
         if ($urandom_range(0, 1) == 1) begin
            value = -value;
         end
      end
      return value;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic queue_request(input conv_mode_type mode, input logic signed [15:0] first_in,
         input logic signed [15:0] second_in, input logic drain);
      coord_request_type item;
      item.mode         = mode;
      item.first_value  = first_in;
      item.second_value = second_in;
      item.gap          = sender_calm ? 5'd0 : 5'(draw_wait());
      item.drain        = drain;
      pending_requests.push_back(item);
   endtask

   // Sender. Whenever the request slot is free (nothing offered, or the offered
   // transaction was taken at this edge) the next request is loaded once its
   // idle cycles have passed. A request marked for draining is held back until
   // no request is on offer and every predicted result has come back.
   always @(posedge clock) begin : sender
      coord_request_type item;
      int unsigned       gap_count;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count = 0;
      end else if (!req_valid || !req_stall) begin
         if (pending_requests.size() == 0) begin
            req_valid <= 1'b0;
         end else if (gap_count < pending_requests[0].gap) begin
            gap_count++;
            req_valid <= 1'b0;
         end else if (pending_requests[0].drain && (req_valid || results_owed != 0)) begin
            req_valid <= 1'b0;
         end else begin
            item = pending_requests.pop_front();
            gap_count = 0;
            req_valid        <= 1'b1;
            req_type         <= item.mode;
            req_first_value  <= item.first_value;
            req_second_value <= item.second_value;
         end
      end
   end

   // Receiver. After each result is taken the stall line is raised for a drawn
   // number of cycles, whether or not the next result is already waiting. Calm
   // windows with no stalling at all are drawn at random among busy ones.
   always @(posedge clock) begin : receiver
      int unsigned stall_left;
      int unsigned window_left;
      logic        receiver_calm;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left    = 0;
         window_left   = 0;
         receiver_calm = 1'b0;
      end else begin
         if (window_left == 0) begin
            receiver_calm = ($urandom_range(0, 3) == 0);
            window_left   = $urandom_range(50, 400);
         end else begin
            window_left--;
         end
         if (rsp_valid && !rsp_stall) begin
            stall_left = receiver_calm ? 0 : draw_wait();
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Scoreboard. A result taken at this edge is compared with the oldest
   // prediction; a request taken at this edge adds its prediction to the back
   // of the queue. Both sides are sampled at the edge, before any of the
   // nonblocking updates of this time step land.
   always @(posedge clock) begin : scoreboard
      awaited_result_type want;
      awaited_result_type fresh;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               report_mismatch($sformatf("result %0d, %0d arrived with nothing predicted",
                  rsp_first_result, rsp_second_result));
            end else begin
               want = awaited_results.pop_front();
               if (rsp_first_result !== want.result.first) begin
                  report_mismatch($sformatf("%s (%0d, %0d): first_result %0d, predicted %0d",
                     want.mode.name(), want.first_value, want.second_value,
                     rsp_first_result, want.result.first));
               end
               if (rsp_second_result !== want.result.second) begin
                  report_mismatch($sformatf("%s (%0d, %0d): second_result %0d, predicted %0d",
                     want.mode.name(), want.first_value, want.second_value,
                     rsp_second_result, want.result.second));
               end
            end
         end
         if (req_valid && !req_stall) begin
            fresh.mode         = conv_mode_type'(req_type);
            fresh.first_value  = req_first_value;
            fresh.second_value = req_second_value;
            fresh.result       = predict_conversion(fresh.mode, req_first_value,
               req_second_value);
            awaited_results.push_back(fresh);
         end
         results_owed <= awaited_results.size();
      end
   end

   // Stimulus and end of run. The directed transactions come first, then the
   // random ones; the sender works through them at its own pace while this
   // block waits for the last result and the pipeline to fall quiet.
   initial begin : stimulus
      int unsigned        count;
      conv_mode_type      mode;
      logic signed [15:0] first_in;
      logic signed [15:0] second_in;

      // Polar extremes: full and most negative radius, angles on and just
      // beyond half pi, at pi, and beyond pi in both directions so that they
      // wrap, a negative radius and a zero radius.
      queue_request(CONV_POLAR_TO_RECT, 16'sd32767, 16'sd0, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, -16'sd32768, 16'sd0, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, 16'sd256, 16'sd25736, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, 16'sd256, 16'sd32767, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, 16'sd256, -16'sd32768, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, 16'sd32767, 16'sd12868, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, 16'sd32767, 16'sd12869, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, 16'sd32767, -16'sd12869, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, -16'sd256, 16'sd4096, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, 16'sd0, 16'sd1000, 1'b0);
      queue_request(CONV_POLAR_TO_RECT, 16'sd12345, -16'sd25736, 1'b0);
      // Rectangular cases: the origin (taken only once the pipeline is empty),
      // the negative x axis which must give +pi, all four corners, the axes
      // and the smallest vectors.
      queue_request(CONV_RECT_TO_POLAR, 16'sd0, 16'sd0, 1'b1);
      queue_request(CONV_RECT_TO_POLAR, -16'sd256, 16'sd0, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, -16'sd32768, -16'sd32768, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, 16'sd32767, 16'sd32767, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, 16'sd32767, -16'sd32768, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, -16'sd32768, 16'sd32767, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, 16'sd0, 16'sd256, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, 16'sd0, -16'sd256, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, -16'sd1, -16'sd1, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, 16'sd256, 16'sd0, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, -16'sd32768, 16'sd0, 1'b0);
      queue_request(CONV_RECT_TO_POLAR, 16'sd1, 16'sd0, 1'b0);

      // Random part. Angles mostly lie within -pi to pi, the rest span the
      // whole input range. Every hundred transactions the sender may switch to
      // a calm stretch without idle cycles, and every few hundred it waits for
      // the pipeline to drain before going on.
      for (count = 0; count < RANDOM_ITEMS; count++) begin
         if (count % 100 == 0) begin
            sender_calm = ($urandom_range(0, 3) == 0);
         end
         mode     = conv_mode_type'($urandom_range(0, 1));
         first_in = pick_value();
         if (mode == CONV_POLAR_TO_RECT && $urandom_range(0, 3) != 0) begin
            second_in = 16'(int'($urandom_range(0, 51472)) - 25736);
         end else begin
            second_in = pick_value();
         end
         queue_request(mode, first_in, second_in, (count % 300 == 299));
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid || results_owed != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(negedge clock);
      if (awaited_results.size() != 0) begin
         report_mismatch($sformatf("%0d predicted results never arrived",
            awaited_results.size()));
      end
      if (mismatch_count == 0) begin
         $display("polar_rectangular_converter verification clean");
      end else begin
         $display("polar_rectangular_converter verification failed");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest possible run.
   initial begin : watchdog
      #20_000_000;
      $display("timeout with %0d requests unsent and %0d results outstanding",
         pending_requests.size(), awaited_results.size());
      $display("polar_rectangular_converter verification failed");
      $finish;
   end

endmodule
